### hdl/dpmd_pkg.sv
// ----------------------------------------------------------------------------
// dpmd_pkg - shared definitions for the deadband pid motor drive
// Field widths, register reset values, register indexes and operand widths
// of the shared multiplier.
// ----------------------------------------------------------------------------
package dpmd_pkg;

  // item field widths
  localparam int unsigned POS_W   = 10;
  localparam int unsigned ERR_W   = 11;
  localparam int unsigned DIFF_W  = 12;
  localparam int unsigned DRIVE_W = 16;
  localparam int unsigned DAC_W   = 12;
  localparam int unsigned SUM_W   = 32;

  // configuration port
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned BAND_W   = 10;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  // shared multiplier operands, signed
  localparam int unsigned MUL_A_W = SUM_W + 1;
  localparam int unsigned MUL_B_W = GAIN_W + 1;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // magnitude bits kept for the time step pass, larger values saturate
  localparam int unsigned MAG_W = 28;

  // register reset values
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd2458;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd410;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd410;
  localparam logic [GAIN_W-1:0] TIME_STEP_RST  = 16'd655;
  localparam logic [BAND_W-1:0] DEAD_BAND_RST  = 10'd10;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    IDX_PROP_GAIN  = 3'd0,
    IDX_INTEG_GAIN = 3'd1,
    IDX_DERIV_GAIN = 3'd2,
    IDX_TIME_STEP  = 3'd3,
    IDX_DEAD_BAND  = 3'd4
  } cfg_idx_e;

  // multiplier operand pair
  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage

### hdl/dpmd_if.sv
// ----------------------------------------------------------------------------
// dpmd_if - channel interfaces of the deadband pid motor drive
// Sample input channel, result output channel and register write channel,
// each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface dpmd_in_if;
  logic                      valid;
  logic                      ready;
  logic [dpmd_pkg::POS_W-1:0] target_pos;
  logic [dpmd_pkg::POS_W-1:0] measured_pos;
  logic                      restart;

  modport source (output valid, target_pos, measured_pos, restart, input ready);
  modport sink   (input valid, target_pos, measured_pos, restart, output ready);
endinterface

interface dpmd_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [dpmd_pkg::DRIVE_W-1:0] drive_level;
  logic [dpmd_pkg::DAC_W-1:0]          forward_dac;
  logic [dpmd_pkg::DAC_W-1:0]          reverse_dac;
  logic                               in_band;

  modport source (output valid, drive_level, forward_dac, reverse_dac, in_band,
                  input ready);
  modport sink   (input valid, drive_level, forward_dac, reverse_dac, in_band,
                  output ready);
endinterface

interface dpmd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dpmd_pkg::CFG_IDX_W-1:0] index;
  logic [dpmd_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/dpmd_mul.sv
// ----------------------------------------------------------------------------
// dpmd_mul - shared signed multiplier
// One signed 33 x 17 bit product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module dpmd_mul (
  input  logic                                  clk_i,
  input  dpmd_pkg::mul_req_t                    req_i,
  output logic signed [dpmd_pkg::MUL_P_W-1:0]   prod_o
);
  import dpmd_pkg::*;

  logic signed [MUL_P_W-1:0] prod_q;

  // product register
  always_ff @(posedge clk_i) begin
    prod_q <= req_i.a * req_i.b;
  end

  assign prod_o = prod_q;

endmodule

### hdl/deadband_pid_motor_drive.sv
// Items inside the deadband skip the multiplier and go straight to the done
// state; items outside pass four times through the one shared multiplier and
// their accumulation. A new item is accepted only in idle, after the result
// of the last one has been loaded into the output registers.
// Reset: gains, time step and deadband take their defaults, the error sum and
// last error clear, no result is pending.
// ----------------------------------------------------------------------------
// deadband_pid_motor_drive - deadband pid controller with split dac drive
// Sequencer over a shared multiplier forming the pid sum, time step scaling,
// Q1.15 saturation and the forward and reverse dac codes.
// ----------------------------------------------------------------------------
module deadband_pid_motor_drive (
  input  logic          clk_i,
  input  logic          rst_ni,
  dpmd_in_if.sink       in_i,
  dpmd_out_if.source    out_o,
  dpmd_cfg_if.sink      cfg_i
);
  import dpmd_pkg::*;

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MULP = 4'd1;
  localparam logic [3:0] S_MULI = 4'd2;
  localparam logic [3:0] S_MULD = 4'd3;
  localparam logic [3:0] S_ADD  = 4'd4;
  localparam logic [3:0] S_ABS  = 4'd5;
  localparam logic [3:0] S_MULT = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state_q, state_d;

  // configuration registers
  logic [GAIN_W-1:0] prop_gain_q, integ_gain_q, deriv_gain_q, time_step_q;
  logic [BAND_W-1:0] dead_band_q;

  // controller state
  logic signed [SUM_W-1:0] error_sum_q;
  logic signed [ERR_W-1:0] last_error_q;

  // working registers
  logic signed [ERR_W-1:0]   err_q;
  logic signed [MUL_P_W-1:0] acc_q, acc_d;
  logic [MAG_W-1:0]          mag_q;
  logic                      neg_q, big_q;

  // result registers
  logic signed [DRIVE_W-1:0] res_drive_q, res_drive_d;
  logic [DAC_W-1:0]          res_fwd_q, res_fwd_d, res_rev_q, res_rev_d;
  logic                      res_band_q, res_band_d;

  // output registers
  logic                      out_valid_q;
  logic signed [DRIVE_W-1:0] out_drive_q;
  logic [DAC_W-1:0]          out_fwd_q, out_rev_q;
  logic                      out_band_q;

  logic in_acc, out_load;

  // error and band test on the incoming item
  logic signed [ERR_W-1:0] err_new;
  logic [POS_W-1:0]        err_mag;
  logic                    band_hit;

  assign err_new  = $signed({1'b0, in_i.target_pos}) - $signed({1'b0, in_i.measured_pos});
  assign err_mag  = err_new[ERR_W-1] ? POS_W'(-err_new) : err_new[POS_W-1:0];
  assign band_hit = (err_mag <= dead_band_q);

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  // shared multiplier
  mul_req_t                  mul_req;
  logic signed [MUL_P_W-1:0] prod;
  logic signed [DIFF_W-1:0]  err_diff;

  assign err_diff = DIFF_W'(err_q) - DIFF_W'(last_error_q);

  always_comb begin
    mul_req.a = '0;
    mul_req.b = '0;
    unique case (state_q)
      S_MULP: begin
        mul_req.a = MUL_A_W'(err_q);
        mul_req.b = $signed({1'b0, prop_gain_q});
      end
      S_MULI: begin
        mul_req.a = MUL_A_W'(error_sum_q);
        mul_req.b = $signed({1'b0, integ_gain_q});
      end
      S_MULD: begin
        mul_req.a = MUL_A_W'(err_diff);
        mul_req.b = $signed({1'b0, deriv_gain_q});
      end
      S_MULT: begin
        mul_req.a = $signed({{(MUL_A_W-MAG_W){1'b0}}, mag_q});
        mul_req.b = $signed({1'b0, time_step_q});
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
  end

  dpmd_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // accumulator of the three gain terms
  always_comb begin
    acc_d = acc_q;
    if (state_q == S_MULI) begin
      acc_d = prod;
    end else if (state_q == S_MULD || state_q == S_ADD) begin
      acc_d = acc_q + prod;
    end
  end

  // magnitude of the gain sum
  logic [MUL_P_W-1:0] acc_abs;
  assign acc_abs = acc_q[MUL_P_W-1] ? MUL_P_W'(-acc_q) : MUL_P_W'(acc_q);

  // saturating error sum update
  logic signed [SUM_W:0]   sum_ext;
  logic signed [SUM_W-1:0] sum_sat;

  assign sum_ext = $signed({error_sum_q[SUM_W-1], error_sum_q}) + (SUM_W+1)'(err_q);
  always_comb begin
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end
  end

  // drive saturation and dac split
  logic [30:0]         drv_mag;
  logic [DRIVE_W-1:0]  neg_drive;
  logic [DAC_W:0]      rev_raw;

  assign drv_mag = prod[43:13];

  always_comb begin
    res_drive_d = res_drive_q;
    res_fwd_d   = res_fwd_q;
    res_rev_d   = res_rev_q;
    res_band_d  = res_band_q;
    neg_drive   = '0;
    rev_raw     = '0;
    if (in_acc && band_hit) begin
      res_drive_d = '0;
      res_fwd_d   = '0;
      res_rev_d   = '0;
      res_band_d  = 1'b1;
    end else if (state_q == S_FIN) begin
      if (big_q && time_step_q == '0) begin
        res_drive_d = '0;
      end else if (neg_q) begin
        if (big_q || drv_mag >= 31'd32768) begin
          res_drive_d = {1'b1, {(DRIVE_W-1){1'b0}}};
        end else begin
          res_drive_d = $signed(DRIVE_W'(0) - drv_mag[DRIVE_W-1:0]);
        end
      end else begin
        if (big_q || drv_mag >= 31'd32767) begin
          res_drive_d = {1'b0, {(DRIVE_W-1){1'b1}}};
        end else begin
          res_drive_d = $signed(drv_mag[DRIVE_W-1:0]);
        end
      end
      // dac magnitudes, reverse capped at full scale
      if (res_drive_d[DRIVE_W-1]) begin
        neg_drive = DRIVE_W'(0) - res_drive_d;
        rev_raw   = neg_drive[DRIVE_W-1:3];
        res_fwd_d = '0;
        res_rev_d = rev_raw[DAC_W] ? {DAC_W{1'b1}} : rev_raw[DAC_W-1:0];
      end else begin
        res_fwd_d = res_drive_d[DRIVE_W-2:3];
        res_rev_d = '0;
      end
      res_band_d = 1'b0;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = band_hit ? S_DONE : S_MULP;
      S_MULP:  state_d = S_MULI;
      S_MULI:  state_d = S_MULD;
      S_MULD:  state_d = S_ADD;
      S_ADD:   state_d = S_ABS;
      S_ABS:   state_d = S_MULT;
      S_MULT:  state_d = S_FIN;
      S_FIN:   state_d = S_DONE;
      S_DONE:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      error_sum_q  <= '0;
      last_error_q <= '0;
      prop_gain_q  <= PROP_GAIN_RST;
      integ_gain_q <= INTEG_GAIN_RST;
      deriv_gain_q <= DERIV_GAIN_RST;
      time_step_q  <= TIME_STEP_RST;
      dead_band_q  <= DEAD_BAND_RST;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      // restart clears before the band test
      if (in_acc && in_i.restart) begin
        error_sum_q  <= '0;
        last_error_q <= '0;
      end else if (state_q == S_FIN) begin
        error_sum_q  <= sum_sat;
        last_error_q <= err_q;
      end
      // register writes
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          IDX_PROP_GAIN:  prop_gain_q  <= cfg_i.data;
          IDX_INTEG_GAIN: integ_gain_q <= cfg_i.data;
          IDX_DERIV_GAIN: deriv_gain_q <= cfg_i.data;
          IDX_TIME_STEP:  time_step_q  <= cfg_i.data;
          IDX_DEAD_BAND:  dead_band_q  <= cfg_i.data[BAND_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      err_q <= err_new;
    end
    acc_q <= acc_d;
    if (state_q == S_ABS) begin
      neg_q <= acc_q[MUL_P_W-1];
      big_q <= |acc_abs[MUL_P_W-1:MAG_W];
      mag_q <= acc_abs[MAG_W-1:0];
    end
    res_drive_q <= res_drive_d;
    res_fwd_q   <= res_fwd_d;
    res_rev_q   <= res_rev_d;
    res_band_q  <= res_band_d;
    if (out_load) begin
      out_drive_q <= res_drive_q;
      out_fwd_q   <= res_fwd_q;
      out_rev_q   <= res_rev_q;
      out_band_q  <= res_band_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.drive_level = out_drive_q;
  assign out_o.forward_dac = out_fwd_q;
  assign out_o.reverse_dac = out_rev_q;
  assign out_o.in_band     = out_band_q;

  // checks
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready)
    else $error("item accepted while busy");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !in_acc) |=> (state_q == S_IDLE))
    else $error("sequencer left idle without an item");

  a_band_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_band_q) |-> (out_drive_q == '0 && out_fwd_q == '0
                                     && out_rev_q == '0))
    else $error("in-band result with nonzero drive");

  a_one_winding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_fwd_q == '0 || out_rev_q == '0))
    else $error("both windings driven");

  a_neg_no_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_drive_q[DRIVE_W-1]) |-> (out_fwd_q == '0))
    else $error("negative drive on forward winding");

endmodule
